### hdl/sdpd_pkg.sv
// types, constants and field arithmetic for the sensor delta packet decoder
// shared by sdpd_decode, sdpd_out_fifo and sensor_delta_packet_decoder_top
// no dependencies
package sdpd_pkg;

  localparam int FLAGS_W = 19;
  localparam int ID_W    = 4;
  localparam int VALUE_W = 32;
  localparam int SEG_W   = 4;
  localparam int POS_W   = 2;
  localparam int LEN_W   = 3;
  localparam int SLOT_W  = 3;
  localparam int SLOTS   = 8;

  localparam logic [3:0] NIBBLE = 4'hF;

  localparam logic [SEG_W-1:0] SEG_TEMP     = 4'd0;
  localparam logic [SEG_W-1:0] SEG_HUMID    = 4'd1;
  localparam logic [SEG_W-1:0] SEG_PRESS    = 4'd2;
  localparam logic [SEG_W-1:0] SEG_IAQ      = 4'd3;
  localparam logic [SEG_W-1:0] SEG_ACCURACY = 4'd4;
  localparam logic [SEG_W-1:0] SEG_STATIC   = 4'd5;
  localparam logic [SEG_W-1:0] SEG_CO2      = 4'd6;
  localparam logic [SEG_W-1:0] SEG_VOC      = 4'd7;
  localparam logic [SEG_W-1:0] SEG_GAS      = 4'd8;
  localparam logic [SEG_W-1:0] SEG_STAB     = 4'd9;
  localparam logic [SEG_W-1:0] SEG_ANALOG   = 4'd10;

  localparam logic [ID_W-1:0] ID_RUNIN  = 4'd10;
  localparam logic [ID_W-1:0] ID_ANALOG = 4'd11;
  localparam logic [ID_W-1:0] ID_WIND   = 4'd12;

  localparam logic [SLOT_W-1:0] SLOT_ANALOG = 3'd6;
  localparam logic [SLOT_W-1:0] SLOT_WIND   = 3'd7;

  localparam logic [3:0] DBIT_NONE   = 4'd0;
  localparam logic [3:0] DBIT_TEMP   = 4'd1;
  localparam logic [3:0] DBIT_PRESS  = 4'd3;
  localparam logic [3:0] DBIT_ANALOG = 4'd8;
  localparam logic [3:0] DBIT_WIND   = 4'd9;

  localparam int ABS_BIT = 0;
  localparam int NEG_OFS = 9;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [VALUE_W-1:0] value;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [LEN_W-1:0] full_len(input logic [SEG_W-1:0] seg);
    logic [LEN_W-1:0] len;
    unique case (seg) inside
      SEG_PRESS:                          len = 3'd4;
      SEG_ACCURACY, SEG_GAS, SEG_STAB:    len = 3'd1;
      SEG_ANALOG:                         len = 3'd3;
      default:                            len = 3'd2;
    endcase
    return len;
  endfunction

  function automatic logic [3:0] delta_bit(input logic [SEG_W-1:0] seg);
    logic [3:0] d;
    unique case (seg)
      SEG_TEMP:   d = 4'd1;
      SEG_HUMID:  d = 4'd2;
      SEG_PRESS:  d = 4'd3;
      SEG_IAQ:    d = 4'd4;
      SEG_STATIC: d = 4'd5;
      SEG_CO2:    d = 4'd6;
      SEG_VOC:    d = 4'd7;
      default:    d = DBIT_NONE;
    endcase
    return d;
  endfunction

  function automatic logic [SLOT_W-1:0] short_slot(input logic [SEG_W-1:0] seg);
    logic [SLOT_W-1:0] s;
    unique case (seg)
      SEG_HUMID:  s = 3'd1;
      SEG_IAQ:    s = 3'd2;
      SEG_STATIC: s = 3'd3;
      SEG_CO2:    s = 3'd4;
      SEG_VOC:    s = 3'd5;
      default:    s = 3'd0;
    endcase
    return s;
  endfunction

  function automatic logic is_short(input logic [SEG_W-1:0] seg);
    logic r;
    unique case (seg) inside
      SEG_TEMP, SEG_HUMID, SEG_IAQ, SEG_STATIC, SEG_CO2, SEG_VOC: r = 1'b1;
      default:                                                    r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] seg_len(input logic [SEG_W-1:0]   seg,
                                               input logic [FLAGS_W-1:0] flags);
    logic [LEN_W-1:0] len;
    logic [3:0]       d;
    d = delta_bit(seg);
    if (seg == SEG_ANALOG) begin
      len = (!flags[ABS_BIT] && flags[DBIT_ANALOG] && flags[DBIT_WIND]) ? 3'd1 : 3'd3;
    end else if (!flags[ABS_BIT] && d != DBIT_NONE && flags[5'(d)]) begin
      len = 3'd1;
    end else begin
      len = full_len(seg);
    end
    return len;
  endfunction

  function automatic logic [15:0] finish_short(input logic [15:0] prev,
                                               input logic [15:0] raw,
                                               input logic        absolute,
                                               input logic        neg,
                                               input logic        is_temp);
    logic [15:0] v;
    if (absolute) begin
      v = (is_temp && neg) ? 16'(-raw) : raw;
    end else begin
      v = prev + (neg ? 16'(-raw) : raw);
    end
    return v;
  endfunction

endpackage

### hdl/sensor_delta_packet_decoder_top.sv
// sensor delta packet decoder: byte channel in, decoded field channel out
// depends on sdpd_pkg, sdpd_decode and sdpd_out_fifo
//
// byte channel: packet_flags, data_byte and first_byte move in one transaction
// when byte_valid is high and byte_stall low; first_byte starts a packet and
// latches its flags
// field channel: field_id, field_value and last move in one transaction when
// field_valid is high and field_stall low; last marks the wind field
// one byte is taken every cycle while the result queue has room for two
// results; a byte's results appear at the earliest after the input register
// and then the queue, one per cycle while the receiver does not stall
// a byte that yields two results fills two queue entries; a stalled
// receiver fills the queue, then byte_stall rises and holds the input
// reset clears the queue, the packet position, the latched flags and all
// stored previous values to zero
// FIFO_DEPTH: result queue depth, a power of two of at least 2
module sensor_delta_packet_decoder_top import sdpd_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic [FLAGS_W-1:0] packet_flags,
  input  logic [7:0]         data_byte,
  input  logic               first_byte,
  output logic               field_valid,
  input  logic               field_stall,
  output logic [ID_W-1:0]    field_id,
  output logic [VALUE_W-1:0] field_value,
  output logic               last
);

  push_t push;
  logic  room;

  sdpd_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .packet_flags (packet_flags),
    .data_byte    (data_byte),
    .first_byte   (first_byte),
    .room         (room),
    .push         (push)
  );

  sdpd_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .room        (room),
    .field_valid (field_valid),
    .field_stall (field_stall),
    .field_id    (field_id),
    .field_value (field_value),
    .last        (last)
  );

endmodule

### hdl/sdpd_decode.sv
// input register, packet position tracking and field decode with stored values
// depends on sdpd_pkg; hands up to two results per byte to sdpd_out_fifo
module sdpd_decode import sdpd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic [FLAGS_W-1:0] packet_flags,
  input  logic [7:0]         data_byte,
  input  logic               first_byte,
  input  logic               room,
  output push_t              push
);

  logic               q_valid;
  logic [FLAGS_W-1:0] q_flags;
  logic [7:0]         q_byte;
  logic               q_first;
  logic               advance;

  logic [SEG_W-1:0]   seg;
  logic [POS_W-1:0]   pos;
  logic               idle;
  logic [FLAGS_W-1:0] flags;
  logic [31:0]        partial;
  logic [15:0]        prev_short [SLOTS];
  logic [31:0]        prev_press;

  logic [SEG_W-1:0]   seg_e;
  logic [POS_W-1:0]   pos_e;
  logic               idle_e;
  logic [FLAGS_W-1:0] flags_e;
  logic [31:0]        partial_e;
  logic [31:0]        flags_ext;
  logic [LEN_W-1:0]   len;
  logic               final_byte;
  logic [31:0]        raw;

  logic [SEG_W-1:0]   seg_next;
  logic [POS_W-1:0]   pos_next;
  logic               idle_next;
  logic [31:0]        partial_next;

  logic               a_we;
  logic [SLOT_W-1:0]  a_slot;
  logic [15:0]        a_raw;
  logic [3:0]         a_dbit;
  logic [4:0]         a_nidx;
  logic [15:0]        a_val;
  logic               b_we;
  logic [15:0]        b_val;
  logic               p_we;
  logic [31:0]        p_val;
  logic [1:0]         n;
  result_t            r0;
  result_t            r1;

  assign byte_stall = q_valid && !room;
  assign advance    = q_valid && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!byte_stall) begin
      q_valid <= byte_valid;
    end
    if (byte_valid && !byte_stall) begin
      q_flags <= packet_flags;
      q_byte  <= data_byte;
      q_first <= first_byte;
    end
  end

  // a packet start overrides the stored position before decode
  assign flags_e   = q_first ? q_flags : flags;
  assign seg_e     = q_first ? '0 : seg;
  assign pos_e     = q_first ? '0 : pos;
  assign idle_e    = q_first ? 1'b0 : idle;
  assign partial_e = q_first ? '0 : partial;
  assign flags_ext = {{(32-FLAGS_W){1'b0}}, flags_e};

  assign len        = seg_len(seg_e, flags_e);
  assign final_byte = (LEN_W'({1'b0, pos_e}) + LEN_W'(1)) >= len;
  assign raw        = {partial_e[23:0], q_byte};

  assign a_nidx = 5'(a_dbit) + 5'(NEG_OFS);
  assign a_val  = finish_short(prev_short[a_slot], a_raw, flags_e[ABS_BIT],
                               flags_ext[a_nidx], a_dbit == DBIT_TEMP);
  assign b_val  = finish_short(prev_short[SLOT_WIND], {12'd0, q_byte[3:0] & NIBBLE},
                               flags_e[ABS_BIT], flags_e[DBIT_WIND + NEG_OFS], 1'b0);
  assign p_val  = flags_e[ABS_BIT] ? raw :
                  prev_press + (flags_e[DBIT_PRESS + NEG_OFS] ? 32'(-raw) : raw);

  always_comb begin
    a_we         = 1'b0;
    a_slot       = short_slot(seg_e);
    a_raw        = raw[15:0];
    a_dbit       = delta_bit(seg_e);
    b_we         = 1'b0;
    p_we         = 1'b0;
    n            = 2'd0;
    r0           = '0;
    r1           = '0;
    partial_next = partial_e;
    idle_next    = idle_e;
    seg_next     = seg_e;
    pos_next     = pos_e;

    if (!idle_e) begin
      if (seg_e == SEG_ANALOG) begin
        if (len == LEN_W'(1)) begin
          a_we   = 1'b1;
          a_slot = SLOT_ANALOG;
          a_raw  = {12'd0, q_byte[7:4]};
          a_dbit = DBIT_ANALOG;
          b_we   = 1'b1;
          n      = 2'd2;
          r0     = '{id: ID_ANALOG, value: {16'd0, a_val}, last: 1'b0};
          r1     = '{id: ID_WIND, value: {16'd0, b_val}, last: 1'b1};
          idle_next = 1'b1;
        end else if (pos_e == POS_W'(0)) begin
          partial_next = {24'd0, q_byte};
        end else if (pos_e == POS_W'(1)) begin
          a_we   = 1'b1;
          a_slot = SLOT_ANALOG;
          a_raw  = {4'd0, partial_e[7:0], q_byte[7:4]};
          a_dbit = DBIT_ANALOG;
          n      = 2'd1;
          r0     = '{id: ID_ANALOG, value: {16'd0, a_val}, last: 1'b0};
          partial_next = {28'd0, q_byte[3:0] & NIBBLE};
        end else begin
          a_we   = 1'b1;
          a_slot = SLOT_WIND;
          a_raw  = {4'd0, partial_e[3:0], q_byte};
          a_dbit = DBIT_WIND;
          n      = 2'd1;
          r0     = '{id: ID_WIND, value: {16'd0, a_val}, last: 1'b1};
          partial_next = '0;
          idle_next    = 1'b1;
        end
      end else if (!final_byte) begin
        partial_next = raw;
      end else begin
        partial_next = '0;
        n = 2'd1;
        if (seg_e == SEG_PRESS) begin
          p_we = 1'b1;
          r0   = '{id: ID_W'(SEG_PRESS), value: p_val, last: 1'b0};
        end else if (is_short(seg_e)) begin
          a_we = 1'b1;
          r0   = '{id: ID_W'(seg_e), value: {16'd0, a_val}, last: 1'b0};
        end else if (seg_e == SEG_STAB) begin
          n  = 2'd2;
          r0 = '{id: ID_W'(SEG_STAB), value: {28'd0, q_byte[7:4]}, last: 1'b0};
          r1 = '{id: ID_RUNIN, value: {28'd0, q_byte[3:0] & NIBBLE}, last: 1'b0};
        end else begin
          r0 = '{id: ID_W'(seg_e), value: {24'd0, q_byte}, last: 1'b0};
        end
      end

      if (seg_e != SEG_ANALOG || len != LEN_W'(1)) begin
        if (final_byte) begin
          seg_next = seg_e + SEG_W'(1);
          pos_next = '0;
        end else begin
          pos_next = pos_e + POS_W'(1);
        end
      end
    end
  end

  always_comb begin
    push       = '0;
    push.r0    = r0;
    push.r1    = r1;
    push.count = advance ? n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg        <= '0;
      pos        <= '0;
      idle       <= 1'b0;
      flags      <= '0;
      partial    <= '0;
      prev_press <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        prev_short[i] <= '0;
      end
    end else if (advance) begin
      seg     <= seg_next;
      pos     <= pos_next;
      idle    <= idle_next;
      flags   <= flags_e;
      partial <= partial_next;
      if (p_we) begin
        prev_press <= p_val;
      end
      if (a_we) begin
        prev_short[a_slot] <= a_val;
      end
      if (b_we) begin
        prev_short[SLOT_WIND] <= b_val;
      end
    end
  end

endmodule

### hdl/sdpd_out_fifo.sv
// result queue taking up to two results a cycle and giving one per transaction
// depends on sdpd_pkg; fed by sdpd_decode
module sdpd_out_fifo import sdpd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  push_t              push,
  output logic               room,
  output logic               field_valid,
  input  logic               field_stall,
  output logic [ID_W-1:0]    field_id,
  output logic [VALUE_W-1:0] field_value,
  output logic               last
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  result_t       mem [DEPTH];
  logic [PW-1:0] wr;
  logic [PW-1:0] rd;
  logic [CW-1:0] count;
  logic          pop;
  result_t       head;

  assign room        = count <= CW'(DEPTH - 2);
  assign field_valid = count != '0;
  assign pop         = field_valid && !field_stall;
  assign head        = mem[rd];
  assign field_id    = head.id;
  assign field_value = head.value;
  assign last        = head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      wr    <= wr + PW'(push.count);
      rd    <= rd + PW'(pop);
      count <= count + CW'(push.count) - CW'(pop);
    end
    if (push.count != 2'd0) begin
      mem[wr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wr + PW'(1)] <= push.r1;
    end
  end

endmodule

### test/tb_sensor_delta_packet_decoder_top.sv
// self-checking testbench for sensor_delta_packet_decoder_top: random packets in,
// decoded fields checked against a field predictor kept inside the bench
// depends on sdpd_pkg and the decoder rtl
module tb_sensor_delta_packet_decoder_top import sdpd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_BYTES = 1250;
  localparam int          HOLD_AT      = 400;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          PAUSE_AT     = 700;
  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          TAIL_CYCLES  = 20;
  localparam logic [4:0]  POS_IDLE     = 5'd31;
  localparam int          SEG_COUNT    = 11;

  typedef struct packed {
    logic               pause;
    logic [FLAGS_W-1:0] flags;
    logic [7:0]         data;
    logic               first;
  } byte_item_t;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               byte_valid   = 1'b0;
  logic               byte_stall;
  logic [FLAGS_W-1:0] packet_flags = '0;
  logic [7:0]         data_byte    = '0;
  logic               first_byte   = 1'b0;
  logic               field_valid;
  logic               field_stall  = 1'b0;
  logic [ID_W-1:0]    field_id;
  logic [VALUE_W-1:0] field_value;
  logic               last;

  // decoder state as the predictor sees it
  logic [4:0]         pos_q;
  logic [FLAGS_W-1:0] flags_q;
  logic [31:0]        partial_q;
  logic [15:0]        prev_short [SLOTS];
  logic [31:0]        prev_press;

  byte_item_t byte_pending_q [$];
  result_t    field_exp_q [$];
  byte_item_t nxt;
  result_t    want;

  int   sent_cnt   = 0;
  int   got_cnt    = 0;
  int   err_cnt    = 0;
  int   pkt_cnt    = 0;
  int   cut_cnt    = 0;
  int   cycle_cnt  = 0;
  int   gap_left   = 0;
  int   stall_left = 0;
  int   hold_left  = 0;
  logic hold_done  = 1'b0;
  logic hold_req   = 1'b0;
  logic hold_off   = 1'b0;
  logic calm       = 1'b0;

  sensor_delta_packet_decoder_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .packet_flags (packet_flags),
    .data_byte    (data_byte),
    .first_byte   (first_byte),
    .field_valid  (field_valid),
    .field_stall  (field_stall),
    .field_id     (field_id),
    .field_value  (field_value),
    .last         (last)
  );

  always #4 clk = ~clk;

  function automatic int delta_index(input int seg);
    int d;
    case (seg)
      SEG_TEMP:   d = 1;
      SEG_HUMID:  d = 2;
      SEG_PRESS:  d = 3;
      SEG_IAQ:    d = 4;
      SEG_STATIC: d = 5;
      SEG_CO2:    d = 6;
      SEG_VOC:    d = 7;
      default:    d = 0;
    endcase
    return d;
  endfunction

  function automatic int seg_bytes(input int seg, input logic [FLAGS_W-1:0] f);
    int d;
    int n;
    d = delta_index(seg);
    if (seg == SEG_ANALOG) begin
      n = (!f[ABS_BIT] && f[DBIT_ANALOG] && f[DBIT_WIND]) ? 1 : 3;
    end else if (!f[ABS_BIT] && d != 0 && f[d]) begin
      n = 1;
    end else begin
      case (seg) inside
        SEG_PRESS:                       n = 4;
        SEG_ACCURACY, SEG_GAS, SEG_STAB: n = 1;
        default:                         n = 2;
      endcase
    end
    return n;
  endfunction

  function automatic int packet_bytes(input logic [FLAGS_W-1:0] f);
    int total;
    total = 0;
    for (int s = 0; s < SEG_COUNT; s++) total += seg_bytes(s, f);
    return total;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    return (r < 85) ? $urandom_range(1, 3) : $urandom_range(6, 30);
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    return (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
  endfunction

  task automatic push_field(input logic [ID_W-1:0] id, input logic [31:0] v, input logic lst);
    result_t r;
    r.id    = id;
    r.value = v;
    r.last  = lst;
    field_exp_q.push_back(r);
  endtask

  task automatic emit_short(input int slot, input logic [ID_W-1:0] id, input logic [15:0] raw,
                            input int dbit, input logic lst);
    logic [15:0] v;
    logic        neg;
    neg = flags_q[dbit + NEG_OFS];
    if (flags_q[ABS_BIT]) begin
      v = (dbit == DBIT_TEMP && neg) ? 16'h0 - raw : raw;
    end else begin
      v = prev_short[slot] + (neg ? 16'h0 - raw : raw);
    end
    prev_short[slot] = v;
    push_field(id, {16'h0, v}, lst);
  endtask

  task automatic decode_byte(input logic [FLAGS_W-1:0] f, input logic [7:0] b,
                             input logic first);
    int          seg;
    int          rel;
    int          len;
    int          d;
    logic [31:0] raw;
    logic        done;
    done = 1'b0;
    len  = 0;
    if (first) begin
      flags_q   = f;
      pos_q     = '0;
      partial_q = '0;
    end
    if (pos_q == POS_IDLE) return;
    rel = pos_q;
    for (seg = 0; seg < SEG_COUNT; seg++) begin
      len = seg_bytes(seg, flags_q);
      if (rel < len) break;
      rel -= len;
    end
    if (seg >= SEG_COUNT) begin
      pos_q = POS_IDLE;
      return;
    end
    if (seg == SEG_ANALOG) begin
      if (len == 1) begin
        emit_short(SLOT_ANALOG, ID_ANALOG, {12'h0, b[7:4]}, DBIT_ANALOG, 1'b0);
        emit_short(SLOT_WIND, ID_WIND, {12'h0, b[3:0]}, DBIT_WIND, 1'b1);
        done = 1'b1;
      end else if (rel == 0) begin
        partial_q = {24'h0, b};
      end else if (rel == 1) begin
        emit_short(SLOT_ANALOG, ID_ANALOG, {4'h0, partial_q[7:0], b[7:4]}, DBIT_ANALOG, 1'b0);
        partial_q = {28'h0, b[3:0]};
      end else begin
        emit_short(SLOT_WIND, ID_WIND, {4'h0, partial_q[3:0], b}, DBIT_WIND, 1'b1);
        partial_q = '0;
        done      = 1'b1;
      end
    end else if (rel + 1 < len) begin
      partial_q = {partial_q[23:0], b};
    end else begin
      raw       = {partial_q[23:0], b};
      partial_q = '0;
      case (seg) inside
        SEG_PRESS: begin
          if (!flags_q[ABS_BIT]) begin
            raw = prev_press + (flags_q[DBIT_PRESS + NEG_OFS] ? 32'h0 - raw : raw);
          end
          prev_press = raw;
          push_field(SEG_PRESS, raw, 1'b0);
        end
        SEG_ACCURACY, SEG_GAS: push_field(ID_W'(seg), {24'h0, b}, 1'b0);
        SEG_STAB: begin
          push_field(SEG_STAB, {28'h0, b[7:4]}, 1'b0);
          push_field(ID_RUNIN, {28'h0, b[3:0]}, 1'b0);
        end
        default: begin
          d = delta_index(seg);
          emit_short((d < 3) ? d - 1 : d - 2, ID_W'(seg), raw[15:0], d, 1'b0);
        end
      endcase
    end
    pos_q = done ? POS_IDLE : pos_q + 5'd1;
  endtask

  task automatic add_byte(input logic [FLAGS_W-1:0] f, input logic [7:0] b, input logic first);
    byte_item_t it;
    it.pause = 1'b0;
    it.flags = f;
    it.data  = b;
    it.first = first;
    byte_pending_q.push_back(it);
  endtask

  task automatic report_bad(input string why, input result_t exp_r);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%s: expected id %0d value %h last %b, got id %0d value %h last %b",
               why, exp_r.id, exp_r.value, exp_r.last, field_id, field_value, last);
    end
  endtask

  // cycle count, quiet stretches and timeout
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt % 128 == 0) calm <= ($urandom_range(0, 3) == 0);
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("TB_ERROR");
      $finish;
    end
  end

  // long receiver hold-off once the sender is well under way
  always @(posedge clk) begin
    if (rst) begin
      hold_off <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_off  <= 1'b1;
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) hold_off <= 1'b0;
    end
  end

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      gap_left   = 0;
    end else begin
      if (byte_valid && !byte_stall) begin
        decode_byte(packet_flags, data_byte, first_byte);
        sent_cnt++;
        if (sent_cnt == HOLD_AT) hold_req <= 1'b1;
        if (!calm && $urandom_range(0, 2) == 0) gap_left = pick_len();
      end
      if (!byte_valid || !byte_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          byte_valid <= 1'b0;
        end else if (byte_pending_q.size() != 0 && byte_pending_q[0].pause) begin
          // wait for every outstanding field before carrying on
          if (field_exp_q.size() == 0) void'(byte_pending_q.pop_front());
          byte_valid <= 1'b0;
        end else if (byte_pending_q.size() != 0) begin
          nxt = byte_pending_q.pop_front();
          packet_flags <= nxt.flags;
          data_byte    <= nxt.data;
          first_byte   <= nxt.first;
          byte_valid   <= 1'b1;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // field monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      field_stall <= 1'b0;
      stall_left  = 0;
    end else begin
      if (field_valid && !field_stall) begin
        got_cnt++;
        if (field_exp_q.size() == 0) begin
          report_bad("unexpected field", '0);
        end else begin
          want = field_exp_q.pop_front();
          if (field_id !== want.id || field_value !== want.value || last !== want.last) begin
            report_bad("field mismatch", want);
          end
        end
      end
      if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) stall_left = pick_len();
      field_stall <= hold_off || (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin
    logic [FLAGS_W-1:0] f;
    int                 counted;
    int                 len;
    int                 n;
    int                 kind;
    logic               paused;
    byte_item_t         stop;
    counted = 0;
    paused  = 1'b0;

    for (int i = 0; i < SLOTS; i++) prev_short[i] = '0;
    pos_q      = '0;
    flags_q    = '0;
    partial_q  = '0;
    prev_press = '0;

    // bytes before any packet start decode as a delta packet with flags clear
    add_byte(19'h7FFFF, 8'hFF, 1'b0);
    add_byte(19'h00000, 8'h80, 1'b0);
    // compact delta packet, every field one byte, all delta fields negated
    add_byte(19'h7FFFE, 8'hFF, 1'b1);
    add_byte(19'h00000, 8'h00, 1'b0);
    add_byte(19'h00000, 8'h80, 1'b0);
    add_byte(19'h00000, 8'h7F, 1'b0);
    add_byte(19'h00000, 8'hFF, 1'b0);
    add_byte(19'h00000, 8'h01, 1'b0);
    add_byte(19'h00000, 8'hFF, 1'b0);
    add_byte(19'h00000, 8'h00, 1'b0);
    add_byte(19'h00000, 8'hAB, 1'b0);
    add_byte(19'h00000, 8'hF0, 1'b0);
    add_byte(19'h00000, 8'h0F, 1'b0);
    // bytes after the packet end are dropped
    add_byte(19'h7FFFF, 8'h5A, 1'b0);
    add_byte(19'h7FFFF, 8'hA5, 1'b0);
    // absolute packet with all negate bits, abandoned after humidity
    add_byte(19'h7FFFF, 8'h80, 1'b1);
    add_byte(19'h00000, 8'h00, 1'b0);
    add_byte(19'h00000, 8'hFF, 1'b0);
    add_byte(19'h00000, 8'hFF, 1'b0);
    pkt_cnt = 3;
    cut_cnt = 1;

    while (counted < RANDOM_BYTES) begin
      kind = $urandom_range(0, 9);
      f    = 19'($urandom_range(0, 19'h7FFFF));
      if (kind < 3) begin
        f[ABS_BIT] = 1'b1;
      end else if (kind == 3) begin
        f = {f[18:10], 9'h1FF, 1'b0};
      end else if (kind == 4) begin
        f = {f[18:10], 9'h000, 1'b0};
      end else begin
        f[ABS_BIT] = 1'b0;
      end
      len = packet_bytes(f);
      n   = len;
      if ($urandom_range(0, 6) == 0) begin
        n = $urandom_range(1, len - 1);
        cut_cnt++;
      end
      pkt_cnt++;
      for (int i = 0; i < n; i++) begin
        add_byte((i == 0) ? f : 19'($urandom_range(0, 19'h7FFFF)), rand_byte(), i == 0);
      end
      counted += n;
      if (n == len && $urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3)) add_byte(19'($urandom_range(0, 19'h7FFFF)),
                                               rand_byte(), 1'b0);
      end
      if (!paused && counted >= PAUSE_AT) begin
        stop       = '0;
        stop.pause = 1'b1;
        byte_pending_q.push_back(stop);
        paused = 1'b1;
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // checked between edges so the driver's update at the edge has settled
    while (byte_pending_q.size() != 0 || byte_valid || field_exp_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (field_exp_q.size() != 0) begin
      err_cnt += field_exp_q.size();
      $display("%0d expected fields never arrived", field_exp_q.size());
    end
    $display("sent %0d bytes in %0d packets (%0d cut short), with noise and a long hold-off",
             sent_cnt, pkt_cnt, cut_cnt);
    $display("checked %0d decoded fields, %0d mismatches", got_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sensor_delta_packet_decoder_top.f
hdl/sdpd_pkg.sv
hdl/sdpd_decode.sv
hdl/sdpd_out_fifo.sv
hdl/sensor_delta_packet_decoder_top.sv
test/tb_sensor_delta_packet_decoder_top.sv
